[rtl/efb_pkg.sv]
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types and constants of the smoothed filter with transient blend:
// action codes, register indexes, shared ALU controls and sequencer states.
// ----------------------------------------------------------------------------
package efb_pkg;

	// Q16.16 one, held in the 17-bit weight format
	localparam int unsigned WGT_W = 17;
	localparam logic [WGT_W-1:0] Q_ONE = 17'h10000;

	localparam int unsigned THR_W = 16;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned DIFF_W = 33;
	localparam int unsigned ALU_W = 34;

	// serial multiply and divide both walk 17 bits
	localparam int unsigned STEPS = 17;
	localparam int unsigned CNT_W = $clog2(STEPS);

	// APB address: two 32-bit registers
	localparam int unsigned APB_AW = 3;

	// action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_REBASE = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_WEIGHT = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	// ALU operand A select
	typedef enum logic [2:0] {
		OPA_ZERO = 3'd0,
		OPA_X    = 3'd1,
		OPA_S    = 3'd2,
		OPA_L    = 3'd3,
		OPA_HI   = 3'd4,
		OPA_P    = 3'd5,
		OPA_T16  = 3'd6
	} opa_t;

	// ALU operand B select
	typedef enum logic [2:0] {
		OPB_S     = 3'd0,
		OPB_DIFF  = 3'd1,
		OPB_DEV   = 3'd2,
		OPB_L     = 3'd3,
		OPB_T17   = 3'd4,
		OPB_MDIFF = 3'd5,
		OPB_PROD  = 3'd6
	} opb_t;

	typedef struct packed {
		opa_t opa;
		opb_t opb;
		logic sub;
	} alu_ctl_t;

	// register values the ALU can pick from
	typedef struct packed {
		logic [VAL_W-1:0]  x;
		logic [VAL_W-1:0]  s;
		logic [VAL_W-1:0]  l;
		logic [VAL_W-1:0]  p;
		logic [VAL_W-1:0]  dev;
		logic [DIFF_W-1:0] diff;
		logic [ALU_W-1:0]  hi;
		logic [WGT_W-1:0]  lo;
		logic [THR_W-1:0]  t;
	} alu_src_t;

	// result handed from the core to the output register
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
		logic             blend;
	} res_t;

	// sequencer states, one-hot
	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_SSUB  = 12'b0000_0000_0010,
		ST_SABS  = 12'b0000_0000_0100,
		ST_SCMP  = 12'b0000_0000_1000,
		ST_MUL   = 12'b0000_0001_0000,
		ST_ACC   = 12'b0000_0010_0000,
		ST_RCHK1 = 12'b0000_0100_0000,
		ST_RCHK2 = 12'b0000_1000_0000,
		ST_RDIV  = 12'b0001_0000_0000,
		ST_RPSUB = 12'b0010_0000_0000,
		ST_ROUT  = 12'b0100_0000_0000,
		ST_SPARE = 12'b1000_0000_0000
	} state_t;

endpackage

[rtl/efb_if.sv]
// ----------------------------------------------------------------------------
// efb_if
// Valid/ready channels of the filter: input items and result items.
// ----------------------------------------------------------------------------
interface efb_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [15:0] sample_value;

	modport source (output valid, action, sample_value, input ready);
	modport sink (input valid, action, sample_value, output ready);
endinterface

interface efb_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] window_value;
	logic               peak_blended;

	modport source (output valid, window_value, peak_blended, input ready);
	modport sink (input valid, window_value, peak_blended, output ready);
endinterface

[rtl/efb_alu.sv]
// ----------------------------------------------------------------------------
// efb_alu
// Shared 34-bit add/subtract unit with operand selection. Serves the EMA
// difference, absolute value, compares, the serial multiply and the divide.
// ----------------------------------------------------------------------------
module efb_alu (
	input  efb_pkg::alu_ctl_t              ctl,
	input  efb_pkg::alu_src_t              src,
	output logic [efb_pkg::ALU_W-1:0]      sum
);

	logic [efb_pkg::ALU_W-1:0] op_a;
	logic [efb_pkg::ALU_W-1:0] op_b;
	logic [efb_pkg::ALU_W-1:0] op_b_inv;

	// operand A: signed values sign-extend, unsigned ones zero-extend
	always_comb begin
		unique case (ctl.opa)
			efb_pkg::OPA_ZERO: op_a = '0;
			efb_pkg::OPA_X:    op_a = {{2{src.x[31]}}, src.x};
			efb_pkg::OPA_S:    op_a = {{2{src.s[31]}}, src.s};
			efb_pkg::OPA_L:    op_a = {2'b00, src.l};
			efb_pkg::OPA_HI:   op_a = src.hi;
			efb_pkg::OPA_P:    op_a = {{2{src.p[31]}}, src.p};
			efb_pkg::OPA_T16:  op_a = {2'b00, src.t, 16'h0000};
			default:           op_a = '0;
		endcase
	end

	// operand B
	always_comb begin
		unique case (ctl.opb)
			efb_pkg::OPB_S:     op_b = {{2{src.s[31]}}, src.s};
			efb_pkg::OPB_DIFF:  op_b = {src.diff[32], src.diff};
			efb_pkg::OPB_DEV:   op_b = {2'b00, src.dev};
			efb_pkg::OPB_L:     op_b = {2'b00, src.l};
			efb_pkg::OPB_T17:   op_b = {1'b0, src.t, 17'h00000};
			// multiplier bit gates the multiplicand
			efb_pkg::OPB_MDIFF: op_b = src.lo[0] ? {src.diff[32], src.diff} : '0;
			// floor(product / 65536) from the product register pair
			efb_pkg::OPB_PROD:  op_b = {src.hi[32:0], src.lo[16]};
			default:            op_b = '0;
		endcase
	end

	// one adder, B inverted with carry-in for subtract
	assign op_b_inv = op_b ^ {efb_pkg::ALU_W{ctl.sub}};
	assign sum = op_a + op_b_inv + {{(efb_pkg::ALU_W-1){1'b0}}, ctl.sub};

endmodule

[rtl/efb_core.sv]
// ----------------------------------------------------------------------------
// efb_core
// Sequencer and datapath registers. Steps one action at a time through the
// shared ALU: EMA update with serial multiply, window read with restoring
// divide for the blend weight, and rebaseline.
// ----------------------------------------------------------------------------
module efb_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [1:0]                     action,
	input  logic [15:0]                    sample_value,
	input  logic [efb_pkg::WGT_W-1:0]      weight,
	input  logic [efb_pkg::THR_W-1:0]      thresh,
	input  logic                           res_free,
	output logic                           idle,
	output efb_pkg::res_t                  res
);

	efb_pkg::state_t state_q;

	logic [efb_pkg::VAL_W-1:0]  x_q;
	logic [efb_pkg::VAL_W-1:0]  s_q;
	logic [efb_pkg::VAL_W-1:0]  l_q;
	logic [efb_pkg::VAL_W-1:0]  p_q;
	logic [efb_pkg::VAL_W-1:0]  dev_q;
	logic [efb_pkg::DIFF_W-1:0] diff_q;
	logic [efb_pkg::ALU_W-1:0]  hi_q;
	logic [efb_pkg::WGT_W-1:0]  lo_q;
	logic [efb_pkg::CNT_W-1:0]  cnt_q;
	logic                       rd_q;
	logic                       sat_q;
	logic [efb_pkg::VAL_W-1:0]  val_q;
	logic                       blend_q;

	logic [efb_pkg::VAL_W-1:0]  x_in;
	logic [efb_pkg::ALU_W-1:0]  sum;
	logic                       neg;
	logic                       last;
	efb_pkg::alu_ctl_t          ctl;
	efb_pkg::alu_src_t          src;

	assign x_in = {sample_value, 16'h0000};
	assign neg  = sum[efb_pkg::ALU_W-1];
	assign last = (cnt_q == '0);
	assign idle = (state_q == efb_pkg::ST_IDLE);

	// shared unit
	assign src = '{x: x_q, s: s_q, l: l_q, p: p_q, dev: dev_q, diff: diff_q,
		hi: hi_q, lo: lo_q, t: thresh};

	efb_alu u_alu (
		.ctl (ctl),
		.src (src),
		.sum (sum)
	);

	// ALU operation per state
	always_comb begin
		unique case (state_q)
			efb_pkg::ST_SSUB:  ctl = '{efb_pkg::OPA_X,    efb_pkg::OPB_S,     1'b1};
			efb_pkg::ST_SABS:  ctl = '{efb_pkg::OPA_ZERO, efb_pkg::OPB_DIFF,  1'b1};
			efb_pkg::ST_SCMP:  ctl = '{efb_pkg::OPA_L,    efb_pkg::OPB_DEV,   1'b1};
			efb_pkg::ST_MUL:   ctl = '{efb_pkg::OPA_HI,   efb_pkg::OPB_MDIFF, 1'b0};
			efb_pkg::ST_ACC:   ctl = '{efb_pkg::OPA_S,    efb_pkg::OPB_PROD,  1'b0};
			efb_pkg::ST_RCHK1: ctl = '{efb_pkg::OPA_T16,  efb_pkg::OPB_L,     1'b1};
			efb_pkg::ST_RCHK2: ctl = '{efb_pkg::OPA_L,    efb_pkg::OPB_T17,   1'b1};
			efb_pkg::ST_RDIV:  ctl = '{efb_pkg::OPA_HI,   efb_pkg::OPB_DIFF,  1'b1};
			efb_pkg::ST_RPSUB: ctl = '{efb_pkg::OPA_P,    efb_pkg::OPB_S,     1'b1};
			default:           ctl = '{efb_pkg::OPA_ZERO, efb_pkg::OPB_S,     1'b0};
		endcase
	end

	// result to the output register
	assign res = '{valid: (state_q == efb_pkg::ST_ROUT) && res_free,
		value: val_q, blend: blend_q};

	// filter state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efb_pkg::ST_IDLE;
			s_q     <= '0;
			l_q     <= '0;
			p_q     <= '0;
			cnt_q   <= '0;
			rd_q    <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				efb_pkg::ST_IDLE: begin
					if (start) begin
						x_q  <= x_in;
						rd_q <= (action == efb_pkg::ACT_READ);
						priority if (action == efb_pkg::ACT_SAMPLE) begin
							state_q <= efb_pkg::ST_SSUB;
						end else if (action == efb_pkg::ACT_READ) begin
							state_q <= efb_pkg::ST_RCHK1;
						end else if (action == efb_pkg::ACT_REBASE) begin
							s_q <= x_in;
							p_q <= x_in;
							l_q <= '0;
						end else begin
							// unused code: no effect
							state_q <= efb_pkg::ST_IDLE;
						end
					end
				end
				// diff = X - S
				efb_pkg::ST_SSUB: begin
					diff_q  <= sum[efb_pkg::DIFF_W-1:0];
					state_q <= efb_pkg::ST_SABS;
				end
				// dev = |diff|
				efb_pkg::ST_SABS: begin
					dev_q   <= diff_q[efb_pkg::DIFF_W-1] ? sum[efb_pkg::VAL_W-1:0]
						: diff_q[efb_pkg::VAL_W-1:0];
					state_q <= efb_pkg::ST_SCMP;
				end
				// new peak if dev > L; then multiply diff by the weight
				efb_pkg::ST_SCMP: begin
					if (neg) begin
						l_q <= dev_q;
						p_q <= x_q;
					end
					hi_q    <= '0;
					lo_q    <= weight;
					cnt_q   <= efb_pkg::CNT_W'(efb_pkg::STEPS - 1);
					state_q <= efb_pkg::ST_MUL;
				end
				// shift-add multiply, LSB of the multiplier first
				efb_pkg::ST_MUL: begin
					hi_q  <= {sum[efb_pkg::ALU_W-1], sum[efb_pkg::ALU_W-1:1]};
					lo_q  <= {sum[0], lo_q[efb_pkg::WGT_W-1:1]};
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						state_q <= efb_pkg::ST_ACC;
					end
				end
				// S + floor(product / 65536)
				efb_pkg::ST_ACC: begin
					if (rd_q) begin
						val_q   <= sum[efb_pkg::VAL_W-1:0];
						blend_q <= 1'b1;
						state_q <= efb_pkg::ST_ROUT;
					end else begin
						s_q     <= sum[efb_pkg::VAL_W-1:0];
						state_q <= efb_pkg::ST_IDLE;
					end
				end
				// blend only when T != 0 and L > T << 16
				efb_pkg::ST_RCHK1: begin
					if ((thresh != '0) && neg) begin
						state_q <= efb_pkg::ST_RCHK2;
					end else begin
						val_q   <= s_q;
						blend_q <= 1'b0;
						state_q <= efb_pkg::ST_ROUT;
					end
				end
				// L >= T << 17 saturates the weight at one
				efb_pkg::ST_RCHK2: begin
					sat_q  <= ~neg;
					hi_q   <= {2'b00, l_q};
					diff_q <= {1'b0, thresh, 16'h0000};
					lo_q   <= '0;
					cnt_q  <= efb_pkg::CNT_W'(efb_pkg::STEPS - 1);
					if (neg) begin
						state_q <= efb_pkg::ST_RDIV;
					end else begin
						state_q <= efb_pkg::ST_RPSUB;
					end
				end
				// restoring divide, one quotient bit per cycle
				efb_pkg::ST_RDIV: begin
					if (!neg) begin
						hi_q <= sum;
					end
					lo_q   <= {lo_q[efb_pkg::WGT_W-2:0], ~neg};
					diff_q <= {1'b0, diff_q[efb_pkg::DIFF_W-1:1]};
					cnt_q  <= cnt_q - 1'b1;
					if (last) begin
						state_q <= efb_pkg::ST_RPSUB;
					end
				end
				// diff = P - S; weight = quotient - 1.0, or 1.0 when saturated
				efb_pkg::ST_RPSUB: begin
					diff_q  <= sum[efb_pkg::DIFF_W-1:0];
					lo_q    <= sat_q ? efb_pkg::Q_ONE : {1'b0, lo_q[efb_pkg::WGT_W-2:0]};
					hi_q    <= '0;
					cnt_q   <= efb_pkg::CNT_W'(efb_pkg::STEPS - 1);
					state_q <= efb_pkg::ST_MUL;
				end
				// hand over the result, then open a new window
				efb_pkg::ST_ROUT: begin
					if (res_free) begin
						l_q     <= '0;
						p_q     <= s_q;
						state_q <= efb_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= efb_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/ema_filter_with_transient_blend.sv]
// Rebaseline and unused actions complete from idle. A sample runs the 17-step
// serial multiply. A window read returns S when there is no blend, multiplies
// at once with a saturated weight, or first runs the 17-step restoring divide
// for the blend weight. Throughput: one item at a time through the shared ALU.
// The result sits in an output register, so a new item is taken while it waits.
// Reset (arst_n low): filter state zero, weight 6554, threshold 0.
// ----------------------------------------------------------------------------
// ema_filter_with_transient_blend
// Smoothed axis filter with peak hold and transient blending (Q16.16), with
// an APB register port and valid/ready item and result channels.
// ----------------------------------------------------------------------------
module ema_filter_with_transient_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efb_pkg::APB_AW-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	efb_item_if.sink                      items,
	efb_result_if.source                  results
);

	logic [efb_pkg::WGT_W-1:0] weight_q;
	logic [efb_pkg::THR_W-1:0] thresh_q;
	logic [efb_pkg::WGT_W-1:0] wr_weight;
	logic                      cfg_wr;

	logic                      res_valid_q;
	logic [efb_pkg::VAL_W-1:0] res_value_q;
	logic                      res_blend_q;
	logic                      res_free;
	logic                      core_idle;
	efb_pkg::res_t             res;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign wr_weight = (pwdata[efb_pkg::WGT_W-1:0] > efb_pkg::Q_ONE) ? efb_pkg::Q_ONE
		: pwdata[efb_pkg::WGT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 17'd6554;
			thresh_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				efb_pkg::REG_WEIGHT: weight_q <= wr_weight;
				efb_pkg::REG_THRESH: thresh_q <= pwdata[efb_pkg::THR_W-1:0];
				default:             thresh_q <= thresh_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			efb_pkg::REG_WEIGHT: prdata = {15'h0000, weight_q};
			efb_pkg::REG_THRESH: prdata = {16'h0000, thresh_q};
			default:             prdata = '0;
		endcase
	end

	// sequencer and shared datapath
	assign items.ready = core_idle;
	assign res_free = ~res_valid_q | results.ready;

	efb_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (items.valid & core_idle),
		.action       (items.action),
		.sample_value (items.sample_value),
		.weight       (weight_q),
		.thresh       (thresh_q),
		.res_free     (res_free),
		.idle         (core_idle),
		.res          (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res.valid) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			res_value_q <= res.value;
			res_blend_q <= res.blend;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.window_value = res_value_q;
	assign results.peak_blended = res_blend_q;

endmodule

[rtl/efb_checker.sv]
// ----------------------------------------------------------------------------
// efb_checker
// Port-level checks of the filter: result hold under backpressure, no result
// from non-read actions, busy after a multi-cycle action.
// ----------------------------------------------------------------------------
module efb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               items_valid,
	input logic               items_ready,
	input logic [1:0]         items_action,
	input logic               results_valid,
	input logic               results_ready,
	input logic signed [31:0] window_value,
	input logic               peak_blended
);

	logic item_xfer;
	assign item_xfer = items_valid & items_ready;

	// a stalled result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && !results_ready |=>
			results_valid && $stable(window_value) && $stable(peak_blended))
		else $error("result changed while stalled");

	// only a window read produces a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && (items_action != efb_pkg::ACT_READ) && !results_valid |=>
			!results_valid)
		else $error("result without a window read");

	// sample and read actions keep the block busy past the transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && ((items_action == efb_pkg::ACT_SAMPLE) ||
			(items_action == efb_pkg::ACT_READ)) |=> !items_ready)
		else $error("input accepted during a multi-cycle action");

	// a new result comes out of a busy block
	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results_valid) |-> $past(!items_ready))
		else $error("result appeared while the block was idle");

endmodule

bind ema_filter_with_transient_blend efb_checker u_efb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.items_valid   (items.valid),
	.items_ready   (items.ready),
	.items_action  (items.action),
	.results_valid (results.valid),
	.results_ready (results.ready),
	.window_value  (results.window_value),
	.peak_blended  (results.peak_blended)
);
